@@ hdl/frb_pkg.sv @@
`default_nettype none
package frb_pkg;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEFAULT     = 4;
    localparam int MAX_FRAME_DEFAULT = 1514;

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int LENGTH_W = 11;
    localparam int STATUS_W = 3;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Operation codes carried in s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes carried in m_tuser.
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic execute;
    } frb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } frb_stat_t;

endpackage
`default_nettype wire

@@ hdl/frame_ring_buffer.sv @@
`default_nettype none
// Receive frame queue with SLOTS slots of MAX_FRAME bytes; one slot always
// stays free, so at most SLOTS-1 frames wait. Each beat on the slave side is
// one item: tuser selects a write (0) or a read (1). A write carries a frame
// byte in tdata[7:0] and marks the frame's final byte with tlast. A frame is
// dropped as a whole when the queue is full at its first byte, and bytes past
// MAX_FRAME are discarded with a truncated status. A read returns the next
// byte of the oldest frame; its length is the stored length clipped to the
// read limit in tdata[23:8], which is sampled only at a frame's first byte.
// Every item yields exactly one result beat on the master side, with the
// status code in tuser and tlast set when the read frees the frame's slot.
// The block handles one item at a time: it latches an item in IDLE and
// resolves it in EXEC into the output register, and it takes no new item
// until that one is resolved. A result waiting in the output register
// holds back only the resolution of the next item, not its acceptance.
// No clearing pass runs after reset.
module frame_ring_buffer #(
    parameter int SLOTS     = frb_pkg::SLOTS_DEFAULT,
    parameter int MAX_FRAME = frb_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // data_byte [7:0], read_limit [23:8].
    input  wire logic [frb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    // opcode [0].
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_byte [7:0], frame_length [18:8], zero padding [23:19].
    output logic [frb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    // status [2:0].
    output logic [frb_pkg::STATUS_W-1:0]       m_tuser
);
    import frb_pkg::*;

    frb_cmd_t  cmd;
    frb_stat_t stat;

    // The controller sequences each item; the datapath holds the queue
    // state, both memories and the result register.
    frb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    frb_datapath #(
        .SLOTS     (SLOTS),
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ hdl/frb_ctrl.sv @@
`default_nettype none
module frb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire frb_pkg::frb_stat_t stat,
    output frb_pkg::frb_cmd_t      cmd
);
    import frb_pkg::*;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // One item at a time: take it in IDLE, resolve it in EXEC once the
    // output register can take the result.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                if (!stat.out_stall)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready      = (state_reg == IDLE);
    assign cmd.load_item = s_tvalid && (state_reg == IDLE);
    assign cmd.execute   = (state_reg == EXEC) && !stat.out_stall;

endmodule
`default_nettype wire

@@ hdl/frb_datapath.sv @@
`default_nettype none
module frb_datapath #(
    parameter int SLOTS     = frb_pkg::SLOTS_DEFAULT,
    parameter int MAX_FRAME = frb_pkg::MAX_FRAME_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire frb_pkg::frb_cmd_t           cmd,
    output frb_pkg::frb_stat_t               stat,
    input  wire logic [frb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [frb_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic [frb_pkg::STATUS_W-1:0]     m_tuser
);
    import frb_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OFF_W  = $clog2(MAX_FRAME);
    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam int DEPTH  = SLOTS * (2 ** OFF_W);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_FRAME);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Latched item.
    logic               item_op_reg;
    logic [BYTE_W-1:0]  item_byte_reg;
    logic               item_last_reg;
    logic [LIMIT_W-1:0] item_limit_reg;

    // Queue state.
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [LEN_W-1:0]  wr_off_reg, wr_off_next;
    logic              dropping_reg, dropping_next;
    logic [LEN_W-1:0]  rd_off_reg, rd_off_next;
    logic [LEN_W-1:0]  rd_len_reg, rd_len_next;

    // Memories and their registered read data.
    logic [BYTE_W-1:0] frame_mem [DEPTH];
    logic [LEN_W-1:0]  len_mem [SLOTS];
    logic [BYTE_W-1:0] rd_byte_q;
    logic [LEN_W-1:0]  len_q;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic [LENGTH_W-1:0] out_len_reg, out_len_next;

    // Working values.
    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W-1:0] tail_inc;
    logic              drop;
    logic              mem_we;
    logic              len_we;
    logic [LEN_W-1:0]  wr_cnt;
    logic [LEN_W-1:0]  clip_max;
    logic [LEN_W-1:0]  clip;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  off_inc;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;

    // Stored length clipped to the frame size and to the caller's limit.
    assign clip_max = (len_q > MAX_LEN) ? MAX_LEN : len_q;
    assign clip     = (LIMIT_W'(clip_max) > item_limit_reg) ?
                      LEN_W'(item_limit_reg) : clip_max;

    assign stat.out_stall = out_valid_reg && !m_tready;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        wr_off_next     = wr_off_reg;
        dropping_next   = dropping_reg;
        rd_off_next     = rd_off_reg;
        rd_len_next     = rd_len_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_len_next    = out_len_reg;
        drop            = 1'b0;
        mem_we          = 1'b0;
        len_we          = 1'b0;
        wr_cnt          = wr_off_reg;
        rlen            = rd_len_reg;
        off_inc         = rd_off_reg + 1'b1;
        if (cmd.execute)
        begin
            out_byte_next = '0;
            out_last_next = 1'b0;
            out_len_next  = '0;
            if (item_op_reg == OP_WRITE)
            begin
                drop = dropping_reg ||
                       ((wr_off_reg == '0) && (head_inc == tail_reg));
                if (drop)
                begin
                    out_status_next = ST_DROPPED;
                    dropping_next   = !item_last_reg;
                    if (item_last_reg)
                    begin
                        wr_off_next = '0;
                    end
                end
                else
                begin
                    if (wr_off_reg < MAX_LEN)
                    begin
                        mem_we          = 1'b1;
                        wr_cnt          = wr_off_reg + 1'b1;
                        out_status_next = ST_STORED;
                    end
                    else
                    begin
                        out_status_next = ST_TRUNC;
                    end
                    wr_off_next = wr_cnt;
                    if (item_last_reg)
                    begin
                        len_we       = 1'b1;
                        out_len_next = LENGTH_W'(wr_cnt);
                        head_next    = head_inc;
                        wr_off_next  = '0;
                    end
                end
            end
            else
            begin
                if ((rd_off_reg == '0) && (tail_reg == head_reg))
                begin
                    out_status_next = ST_EMPTY;
                end
                else if ((rd_off_reg == '0) && (clip == '0))
                begin
                    out_status_next = ST_ZERO;
                    out_last_next   = 1'b1;
                    rd_len_next     = '0;
                    tail_next       = tail_inc;
                end
                else
                begin
                    if (rd_off_reg == '0)
                    begin
                        rlen        = clip;
                        rd_len_next = clip;
                    end
                    out_status_next = ST_READ;
                    out_byte_next   = rd_byte_q;
                    out_len_next    = LENGTH_W'(rlen);
                    if (off_inc >= rlen)
                    begin
                        out_last_next = 1'b1;
                        rd_off_next   = '0;
                        tail_next     = tail_inc;
                    end
                    else
                    begin
                        rd_off_next = off_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            wr_off_reg    <= '0;
            dropping_reg  <= 1'b0;
            rd_off_reg    <= '0;
            rd_len_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            wr_off_reg   <= wr_off_next;
            dropping_reg <= dropping_next;
            rd_off_reg   <= rd_off_next;
            rd_len_reg   <= rd_len_next;
            if (cmd.execute)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_op_reg    <= s_tuser;
            item_byte_reg  <= s_tdata[BYTE_W-1:0];
            item_last_reg  <= s_tlast;
            item_limit_reg <= s_tdata[BYTE_W+LIMIT_W-1:BYTE_W];
        end
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_len_reg    <= out_len_next;
    end

    // Both memories are read every cycle at the current tail position, so
    // the data is ready by the time an accepted item is resolved.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[{head_reg, wr_off_reg[OFF_W-1:0]}] <= item_byte_reg;
        end
        rd_byte_q <= frame_mem[{tail_reg, rd_off_reg[OFF_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[head_reg] <= wr_cnt;
        end
        len_q <= len_mem[tail_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - BYTE_W - LENGTH_W)'(0), out_len_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    // A dropped frame never advances the write offset.
    a_drop_offset: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> (wr_off_reg == '0))
        else $error("write offset moved while dropping a frame");

    // A read in progress keeps its offset below the frame's latched length.
    a_read_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_off_reg != '0) |-> (rd_off_reg < rd_len_reg))
        else $error("read offset ran past the frame length");

    // A read in progress implies the queue holds a frame.
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_off_reg != '0) |-> (tail_reg != head_reg))
        else $error("read in progress on an empty queue");

    // The write offset never passes the frame size.
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_off_reg <= MAX_LEN)
        else $error("write offset beyond maximum frame size");

endmodule
`default_nettype wire
